// ===== sv/lru_page_replacement_defines.svh =====
// ----------------------------------------------------------------------------
// LRU page replacement assertion macros
// Shared property shorthands for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LPR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg
// Types and fixed constants shared by the LRU page replacement block.
// ----------------------------------------------------------------------------
package lpr_pkg;

	// width and reset value of the frame count register
	localparam int unsigned FRAMES_W = 5;
	localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd4;

	// width of the reported frame index
	localparam int unsigned FRAME_IDX_W = 4;

	// engine sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_DONE
	} lpr_state_t;

	// engine status seen by the top level
	typedef struct packed {
		logic busy;
		logic result_pending;
	} lpr_status_t;

endpackage

// ===== sv/lpr_frame_mem.sv =====
// ----------------------------------------------------------------------------
// lpr_frame_mem
// Frame table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpr_frame_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 20,
	parameter int unsigned AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read entry into the registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/lpr_engine.sv =====
// ----------------------------------------------------------------------------
// lpr_engine
// Reference sequencer: scan pass for lookup and victim, update pass for ranks,
// running counts, then the output register.
// ----------------------------------------------------------------------------
module lpr_engine #(
	parameter int unsigned MAX_FRAMES = 16,
	parameter int unsigned PAGE_BITS  = 16,
	parameter int unsigned COUNT_BITS = 32,
	parameter int unsigned IDX_W      = 4,
	parameter int unsigned CNT_W      = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [CNT_W-1:0]                 n_active,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [PAGE_BITS-1:0]             page_number,
	input  logic                             last_reference,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             hit,
	output logic [lpr_pkg::FRAME_IDX_W-1:0]  frame_index,
	output logic                             evicted_valid,
	output logic [PAGE_BITS-1:0]             evicted_page,
	output logic [COUNT_BITS-1:0]            hit_total,
	output logic [COUNT_BITS-1:0]            fault_total,
	output logic                             end_of_string,
	// frame memory
	output logic                             mem_re,
	output logic [IDX_W-1:0]                 mem_ra,
	output logic                             mem_we,
	output logic [IDX_W-1:0]                 mem_wa,
	output logic [PAGE_BITS+IDX_W-1:0]       mem_wd,
	input  logic [PAGE_BITS+IDX_W-1:0]       mem_rd,
	// status
	output lpr_pkg::lpr_status_t             status
);

	import lpr_pkg::*;

	localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(MAX_FRAMES - 1);

	lpr_state_t state_q, state_d;

	logic [CNT_W-1:0]      rd_i_q;
	logic                  rd_v_s1;
	logic [IDX_W-1:0]      idx_s1;

	logic [PAGE_BITS-1:0]  pg_q;
	logic                  last_q;
	logic                  found_q;
	logic [IDX_W-1:0]      hit_k_q;
	logic [IDX_W-1:0]      hit_rank_q;
	logic                  empty_q;
	logic [IDX_W-1:0]      empty_k_q;
	logic [IDX_W-1:0]      best_q;
	logic [IDX_W-1:0]      vic_k_q;
	logic [PAGE_BITS-1:0]  vic_page_q;
	logic [IDX_W-1:0]      k_q;
	logic [MAX_FRAMES-1:0] valid_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic [COUNT_BITS-1:0] fault_cnt_q;

	logic                  out_valid_q;
	logic                  hit_q;
	logic [IDX_W-1:0]      frame_q;
	logic                  ev_valid_q;
	logic [PAGE_BITS-1:0]  ev_page_q;
	logic [COUNT_BITS-1:0] hit_tot_q;
	logic [COUNT_BITS-1:0] fault_tot_q;
	logic                  eos_q;

	logic                  in_pass;
	logic                  issue;
	logic                  pass_end;
	logic                  in_accept;
	logic                  out_load;
	logic                  ent_valid;
	logic [PAGE_BITS-1:0]  ent_page;
	logic [IDX_W-1:0]      ent_rank;
	logic [IDX_W-1:0]      k_sel;
	logic [IDX_W-1:0]      rank_lim;
	logic [IDX_W-1:0]      upd_rank;
	logic [PAGE_BITS-1:0]  upd_page;
	logic                  ev_valid;

	// pass control
	assign in_pass   = (state_q == ST_SCAN) || (state_q == ST_UPDATE);
	assign issue     = in_pass && (rd_i_q < n_active);
	assign pass_end  = in_pass && !issue && !rd_v_s1;
	assign in_accept = in_valid && (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// read entry as seen through its valid bit; empty frames read as zero
	always_comb begin
		ent_valid = valid_q[idx_s1];
		ent_page  = ent_valid ? mem_rd[PAGE_BITS+IDX_W-1:IDX_W] : '0;
		ent_rank  = ent_valid ? mem_rd[IDX_W-1:0] : '0;
	end

	// choose the frame and compute the update for the entry in flight
	always_comb begin
		if (found_q) begin
			k_sel    = hit_k_q;
			rank_lim = hit_rank_q;
		end else begin
			k_sel    = empty_q ? empty_k_q : vic_k_q;
			rank_lim = RANK_MAX;
		end
		if (idx_s1 == k_q) begin
			upd_rank = '0;
			upd_page = found_q ? ent_page : pg_q;
		end else begin
			upd_rank = (ent_valid && (ent_rank < rank_lim)) ? ent_rank + 1'b1 : ent_rank;
			upd_page = ent_page;
		end
		ev_valid = !found_q && !empty_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (pass_end) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (pass_end) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall              = (state_q != ST_IDLE);
		mem_re                = issue;
		mem_ra                = rd_i_q[IDX_W-1:0];
		mem_we                = (state_q == ST_UPDATE) && rd_v_s1;
		mem_wa                = idx_s1;
		mem_wd                = {upd_page, upd_rank};
		status.busy           = (state_q != ST_IDLE);
		status.result_pending = (state_q == ST_DONE);
	end

	// advance the sequencer and the read pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_i_q  <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (in_accept || pass_end) begin
				rd_i_q <= '0;
			end else if (issue) begin
				rd_i_q <= rd_i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_i_q[IDX_W-1:0];
	end

	// capture the beat and gather lookup results over the scan pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (in_accept) begin
			found_q <= 1'b0;
			empty_q <= 1'b0;
		end else if ((state_q == ST_SCAN) && rd_v_s1) begin
			if (ent_valid && (ent_page == pg_q) && !found_q) found_q <= 1'b1;
			if (!ent_valid && !empty_q) empty_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pg_q   <= page_number;
			last_q <= last_reference;
		end
		if ((state_q == ST_SCAN) && rd_v_s1) begin
			if (ent_valid && (ent_page == pg_q) && !found_q) begin
				hit_k_q    <= idx_s1;
				hit_rank_q <= ent_rank;
			end
			if (!ent_valid && !empty_q) begin
				empty_k_q <= idx_s1;
			end
			// highest rank wins, lowest index on ties
			if ((idx_s1 == '0) || (ent_rank > best_q)) begin
				best_q     <= ent_rank;
				vic_k_q    <= idx_s1;
				vic_page_q <= ent_page;
			end
		end
		if ((state_q == ST_SCAN) && pass_end) begin
			k_q <= k_sel;
		end
	end

	// mark frame valid and bump the saturating counts at the end of the update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
		end else if ((state_q == ST_UPDATE) && pass_end) begin
			valid_q[k_q] <= 1'b1;
			if (found_q) begin
				if (hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + 1'b1;
			end else begin
				if (fault_cnt_q != '1) fault_cnt_q <= fault_cnt_q + 1'b1;
			end
		end
	end

	// output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the counts with the beat so a stalled result does not change
	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q       <= found_q;
			frame_q     <= k_q;
			ev_valid_q  <= ev_valid;
			ev_page_q   <= ev_valid ? vic_page_q : '0;
			hit_tot_q   <= hit_cnt_q;
			fault_tot_q <= fault_cnt_q;
			eos_q       <= last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_index   = FRAME_IDX_W'(frame_q);
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign hit_total     = hit_tot_q;
	assign fault_total   = fault_tot_q;
	assign end_of_string = eos_q;

endmodule

// ===== sv/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page frame engine with saturating hit/fault counts.
// ----------------------------------------------------------------------------
// Each page reference is accepted, walked through a scan pass and an update
// pass, and then has its result loaded into the output register; the engine
// then returns to idle to take the next reference. Each pass issues one read
// per frame in use, drains the last read and then closes the pass. The frame
// table lives in one single-port-read memory, so the block walks it twice per
// reference: a scan pass for hit lookup, first empty frame and LRU victim,
// then a read-modify-write pass that ages the recency ranks. One reference is
// in work at a time; a new one is taken while the previous result still sits
// in the output register, and the engine holds its finished result, with the
// input stalled, until that register is free. Frame valid bits are flops
// cleared by reset, so no clearing pass is needed. frames_in_use of 0 acts as
// 1 and values above MAX_FRAMES act as MAX_FRAMES; write it only while the
// block is idle.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_defines.svh"

module lru_page_replacement #(
	parameter int unsigned MAX_FRAMES = 16,
	parameter int unsigned PAGE_BITS  = 16,
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lpr_pkg::FRAMES_W-1:0]     frames_in_use,
	// reference input
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [PAGE_BITS-1:0]             page_number,
	input  logic                             last_reference,
	// result output
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             hit,
	output logic [lpr_pkg::FRAME_IDX_W-1:0]  frame_index,
	output logic                             evicted_valid,
	output logic [PAGE_BITS-1:0]             evicted_page,
	output logic [COUNT_BITS-1:0]            hit_total,
	output logic [COUNT_BITS-1:0]            fault_total,
	output logic                             end_of_string
);

	import lpr_pkg::*;

	localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int unsigned ENT_W = PAGE_BITS + IDX_W;

	logic [FRAMES_W-1:0] frames_q;
	logic [CNT_W-1:0]    n_active;
	logic                mem_re;
	logic [IDX_W-1:0]    mem_ra;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_wa;
	logic [ENT_W-1:0]    mem_wd;
	logic [ENT_W-1:0]    mem_rd;
	lpr_status_t         status;

	// frame count register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frames_q <= frames_in_use;
		end
	end

	// clamp the frame count to 1..MAX_FRAMES
	always_comb begin
		if (frames_q == '0) begin
			n_active = CNT_W'(1);
		end else if (32'(frames_q) > MAX_FRAMES) begin
			n_active = CNT_W'(MAX_FRAMES);
		end else begin
			n_active = CNT_W'(frames_q);
		end
	end

	lpr_engine #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.COUNT_BITS (COUNT_BITS),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.n_active       (n_active),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.page_number    (page_number),
		.last_reference (last_reference),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.frame_index    (frame_index),
		.evicted_valid  (evicted_valid),
		.evicted_page   (evicted_page),
		.hit_total      (hit_total),
		.fault_total    (fault_total),
		.end_of_string  (end_of_string),
		.mem_re         (mem_re),
		.mem_ra         (mem_ra),
		.mem_we         (mem_we),
		.mem_wa         (mem_wa),
		.mem_wd         (mem_wd),
		.mem_rd         (mem_rd),
		.status         (status)
	);

	lpr_frame_mem #(
		.DEPTH (MAX_FRAMES),
		.WIDTH (ENT_W),
		.AW    (IDX_W)
	) u_frame_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_wa),
		.wr_data (mem_wd),
		.rd_en   (mem_re),
		.rd_addr (mem_ra),
		.rd_data (mem_rd)
	);

	// an accepted reference keeps the input stalled on the next cycle
	`LPR_ASSERT_NEXT(a_accept_then_busy, clk, arst_n, in_valid && !in_stall, in_stall && status.busy, "input not stalled after accepted beat")

	// a new result only appears out of the result-pending step
	`LPR_ASSERT_IMPLIES(a_result_source, clk, arst_n, $rose(out_valid), $past(status.result_pending), "result appeared without a finished reference")

	// a hit never evicts
	`LPR_ASSERT_IMPLIES(a_hit_no_evict, clk, arst_n, out_valid, !(hit && evicted_valid), "hit reported with an eviction")

endmodule

// ===== test/lru_page_replacement_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_tb
// Drives page references into the LRU frame engine. Results are checked
// against an in-bench LRU scoreboard model. A directed table covers the
// reset state, page extremes, eviction and frame-count edge values. Random
// strings of references with reused working sets then run under several
// frame counts, with random idling on both sides.
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;
	import lpr_pkg::*;

	localparam int unsigned MAX_FRAMES   = 16;
	localparam int unsigned RANK_MAX     = MAX_FRAMES - 1;
	localparam int unsigned RANDOM_REFS  = 1400;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned DRAIN_CYCLES = 2 * MAX_FRAMES + 6;
	localparam int unsigned POOL_SIZE    = 24;
	localparam int unsigned DIR_ROWS     = 21;

	typedef struct packed {
		logic                   hit;
		logic [FRAME_IDX_W-1:0] frame_index;
		logic                   evicted_valid;
		logic [15:0]            evicted_page;
		logic [31:0]            hit_total;
		logic [31:0]            fault_total;
		logic                   end_of_string;
	} ref_result_t;

	typedef struct packed {
		logic                do_cfg;
		logic [FRAMES_W-1:0] cfg_val;
		logic [15:0]         page;
		logic                last;
		logic                typed;
		ref_result_t         res;
	} ref_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [FRAMES_W-1:0]    frames_in_use;
	logic                   in_valid;
	logic                   in_stall;
	logic [15:0]            page_number;
	logic                   last_reference;
	logic                   out_valid;
	logic                   out_stall;
	logic                   hit;
	logic [FRAME_IDX_W-1:0] frame_index;
	logic                   evicted_valid;
	logic [15:0]            evicted_page;
	logic [31:0]            hit_total;
	logic [31:0]            fault_total;
	logic                   end_of_string;

	// shadow frame table and counts
	logic [15:0]         lru_page [MAX_FRAMES];
	bit                  lru_valid [MAX_FRAMES];
	int unsigned         lru_rank [MAX_FRAMES];
	logic [31:0]         hit_cnt;
	logic [31:0]         fault_cnt;
	logic [FRAMES_W-1:0] frames_cfg;

	ref_result_t pending_res [$];
	int          err_cnt = 0;
	int unsigned ref_cnt = 0;
	int unsigned cfg_cnt = 0;
	int unsigned idle_cycles = 0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;

	// after reset: empty frames, page 0 must miss; then fill, hit, and evict
	ref_row_t dir_tab [DIR_ROWS] = '{
		'{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1,
			'{1'b0, 4'd0, 1'b0, 16'h0000, 32'd0, 32'd1, 1'b0}},
		'{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1,
			'{1'b1, 4'd0, 1'b0, 16'h0000, 32'd1, 32'd1, 1'b0}},
		'{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1,
			'{1'b0, 4'd1, 1'b0, 16'h0000, 32'd1, 32'd2, 1'b0}},
		'{1'b0, 5'd0,  16'h0001, 1'b0, 1'b1,
			'{1'b0, 4'd2, 1'b0, 16'h0000, 32'd1, 32'd3, 1'b0}},
		'{1'b0, 5'd0,  16'h0002, 1'b0, 1'b1,
			'{1'b0, 4'd3, 1'b0, 16'h0000, 32'd1, 32'd4, 1'b0}},
		// all four frames full: page 0 in frame 0 is the oldest
		'{1'b0, 5'd0,  16'h0003, 1'b0, 1'b1,
			'{1'b0, 4'd0, 1'b1, 16'h0000, 32'd1, 32'd5, 1'b0}},
		'{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  16'h8000, 1'b1, 1'b0, '0},
		// zero frames acts as one
		'{1'b1, 5'd0,  16'h5555, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  16'h5555, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  16'hAAAA, 1'b0, 1'b0, '0},
		// count above the maximum; old frames come back into the search
		'{1'b1, 5'd31, 16'hFFFF, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  16'h1234, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  16'h0FF0, 1'b0, 1'b0, '0},
		'{1'b1, 5'd16, 16'h0003, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  16'hF00F, 1'b0, 1'b0, '0},
		// shrink mid-string: frame holding 1234 drops out of the search
		'{1'b1, 5'd2,  16'h1234, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  16'h00FF, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  16'hFF00, 1'b0, 1'b0, '0},
		'{1'b1, 5'd17, 16'h1234, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0,  16'h8001, 1'b1, 1'b0, '0}
	};

	lru_page_replacement u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.frames_in_use  (frames_in_use),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.page_number    (page_number),
		.last_reference (last_reference),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.frame_index    (frame_index),
		.evicted_valid  (evicted_valid),
		.evicted_page   (evicted_page),
		.hit_total      (hit_total),
		.fault_total    (fault_total),
		.end_of_string  (end_of_string)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one reference to the shadow table and return the result
	function automatic ref_result_t lru_lookup(input logic [15:0] pg, input logic lst);
		ref_result_t r;
		int unsigned n, k, i, best, hit_rank;
		bit found, empty;
		r = '0;
		k = 0;
		found = 1'b0;
		empty = 1'b0;
		n = (frames_cfg == 0) ? 1 : ((frames_cfg > MAX_FRAMES) ? MAX_FRAMES : frames_cfg);
		for (i = 0; i < n; i++) begin
			if (!found && lru_valid[i] && lru_page[i] == pg) begin
				k = i;
				found = 1'b1;
			end
		end
		if (found) begin
			// age only frames newer than the hit frame
			hit_rank = lru_rank[k];
			for (i = 0; i < n; i++) begin
				if (i != k && lru_valid[i] && lru_rank[i] < hit_rank)
					lru_rank[i]++;
			end
			lru_rank[k] = 0;
			if (hit_cnt != '1)
				hit_cnt++;
		end else begin
			for (i = 0; i < n; i++) begin
				if (!empty && !lru_valid[i]) begin
					k = i;
					empty = 1'b1;
				end
			end
			// no empty frame: highest rank goes, lowest index on ties
			if (!empty) begin
				best = 0;
				k = 0;
				for (i = 0; i < n; i++) begin
					if (i == 0 || lru_rank[i] > best) begin
						best = lru_rank[i];
						k = i;
					end
				end
				r.evicted_valid = 1'b1;
				r.evicted_page = lru_page[k];
			end
			for (i = 0; i < n; i++) begin
				if (i != k && lru_valid[i] && lru_rank[i] < RANK_MAX)
					lru_rank[i]++;
			end
			lru_page[k] = pg;
			lru_valid[k] = 1'b1;
			lru_rank[k] = 0;
			if (fault_cnt != '1)
				fault_cnt++;
		end
		r.hit = found;
		r.frame_index = FRAME_IDX_W'(k);
		r.hit_total = hit_cnt;
		r.fault_total = fault_cnt;
		r.end_of_string = lst;
		return r;
	endfunction

	// offer one reference beat after a random gap; predict on acceptance
	task automatic send_ref(input logic [15:0] pg, input logic lst, output ref_result_t pred);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		page_number <= pg;
		last_reference <= lst;
		do @(posedge clk); while (in_stall);
		pred = lru_lookup(pg, lst);
		ref_cnt++;
	endtask

	// drop valid and wait until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	// write the frame count while the engine is idle
	task automatic write_frames(input logic [FRAMES_W-1:0] count);
		drain_results();
		cfg_valid <= 1'b1;
		frames_in_use <= count;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		frames_cfg = count;
		cfg_cnt++;
	endtask

	// result sink: random stall per beat, one long hold on request
	initial begin
		int unsigned gap;
		out_stall = 1'b1;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = quiet ? 0 : $urandom_range(0, 14);
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		ref_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_res.size() == 0) begin
				$error("result beat with no reference outstanding");
				err_cnt++;
			end else begin
				want = pending_res.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					err_cnt++;
				end
				if (frame_index !== want.frame_index) begin
					$error("frame_index: expected %0d, got %0d", want.frame_index, frame_index);
					err_cnt++;
				end
				if (evicted_valid !== want.evicted_valid) begin
					$error("evicted_valid: expected %0d, got %0d", want.evicted_valid,
						evicted_valid);
					err_cnt++;
				end
				if (evicted_page !== want.evicted_page) begin
					$error("evicted_page: expected %0h, got %0h", want.evicted_page,
						evicted_page);
					err_cnt++;
				end
				if (hit_total !== want.hit_total) begin
					$error("hit_total: expected %0d, got %0d", want.hit_total, hit_total);
					err_cnt++;
				end
				if (fault_total !== want.fault_total) begin
					$error("fault_total: expected %0d, got %0d", want.fault_total, fault_total);
					err_cnt++;
				end
				if (end_of_string !== want.end_of_string) begin
					$error("end_of_string: expected %0d, got %0d", want.end_of_string,
						end_of_string);
					err_cnt++;
				end
			end
		end
	end

	// watchdog: stop when no beat moves on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		ref_result_t pred;
		ref_row_t row;
		logic [15:0] pool [POOL_SIZE];
		logic [FRAMES_W-1:0] fsel;
		logic [15:0] pg;
		logic lst;
		int unsigned phase, len, ws, j, k;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		frames_in_use = FRAMES_RESET;
		in_valid = 1'b0;
		page_number = '0;
		last_reference = 1'b0;

		// clear the shadow table to its reset state
		for (j = 0; j < MAX_FRAMES; j++) begin
			lru_page[j] = '0;
			lru_valid[j] = 1'b0;
			lru_rank[j] = 0;
		end
		hit_cnt = '0;
		fault_cnt = '0;
		frames_cfg = FRAMES_RESET;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// walk the directed table
		for (j = 0; j < DIR_ROWS; j++) begin
			row = dir_tab[j];
			if (row.do_cfg)
				write_frames(row.cfg_val);
			send_ref(row.page, row.last, pred);
			pending_res.push_back(row.typed ? row.res : pred);
		end

		// random strings over a slowly changing working set
		for (j = 0; j < POOL_SIZE; j++)
			pool[j] = 16'($urandom);
		phase = 0;
		while (ref_cnt < DIR_ROWS + RANDOM_REFS) begin
			case ($urandom_range(0, 9))
				0: fsel = '0;
				1: fsel = FRAMES_W'($urandom_range(MAX_FRAMES + 1, 31));
				2: fsel = FRAMES_W'(MAX_FRAMES);
				3: fsel = FRAMES_W'(1);
				default: fsel = FRAMES_W'($urandom_range(1, MAX_FRAMES));
			endcase
			write_frames(fsel);
			for (j = $urandom_range(0, 8); j > 0; j--)
				pool[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom);
			ws = $urandom_range(1, POOL_SIZE);
			len = $urandom_range(20, 80);
			quiet = ($urandom_range(0, 4) == 0);
			// back up the output once so the input stalls
			if (phase == 1) begin
				quiet = 1'b1;
				hold_req = 1'b1;
			end
			for (k = 0; k < len; k++) begin
				if ($urandom_range(0, 9) == 0)
					pg = 16'($urandom);
				else
					pg = pool[$urandom_range(0, ws - 1)];
				lst = (k == len - 1) || ($urandom_range(0, 31) == 0);
				send_ref(pg, lst, pred);
				pending_res.push_back(pred);
			end
			phase++;
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("ran %0d references (%0d hits, %0d faults) across %0d frame count writes",
			ref_cnt, hit_cnt, fault_cnt, cfg_cnt);
		if (err_cnt == 0 && pending_res.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
